// ===== rtl/core/frustum_point_containment_unit_assert.svh =====
// Assertion macros for the frustum point containment unit.
// Included by the top level; depends on nothing else.
`ifndef FRUSTUM_POINT_CONTAINMENT_UNIT_ASSERT_SVH
`define FRUSTUM_POINT_CONTAINMENT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frustum unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define FPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frustum unit: next-cycle check failed");

`endif

// ===== rtl/core/fpc_pkg.sv =====
// Package for the frustum point containment unit: widths, payload types and
// matrix entry helpers. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package fpc_pkg;

   localparam int FIELD_W      = 32;
   localparam int COORD_BITS   = 32;
   localparam int FRAC_BITS    = 16;
   localparam int PLANE_COUNT  = 6;
   localparam int ROW_COUNT    = 4;
   localparam int VP_REG_COUNT = 8;
   localparam int VP_REG_W     = 2 * FIELD_W;
   localparam int VP_SEL_W     = $clog2(VP_REG_COUNT);
   localparam int CSR_INDEX_W  = VP_SEL_W + 1;

   localparam int COEF_W     = COORD_BITS + 1;
   localparam int PROD_W     = COEF_W + COORD_BITS;
   localparam int D_ALIGN_W  = COEF_W + FRAC_BITS;
   localparam int SUM_BASE_W = (PROD_W > D_ALIGN_W) ? PROD_W : D_ALIGN_W;
   localparam int ACC_W      = SUM_BASE_W + 2;

   // Stages from the input register to the plane verdict register.
   localparam int PIPE_DEPTH = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COEF_W-1:0]     coef_val_type;
   typedef logic [VP_REG_W-1:0]          vp_reg_type;
   typedef vp_reg_type [VP_REG_COUNT-1:0] vp_bank_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      coef_val_type a;
      coef_val_type b;
      coef_val_type c;
      coef_val_type d;
      logic         skip;
   } plane_coef_type;

   typedef plane_coef_type [PLANE_COUNT-1:0] plane_coef_set_type;

   // Keep the low COORD_BITS bits of a 32-bit slot as a signed value.
   function automatic coord_type sext_coord(input logic [FIELD_W-1:0] v);
      return coord_type'(v[COORD_BITS-1:0]);
   endfunction

   // Matrix entry at a zero-based row and column.
   function automatic coord_type vp_entry(input vp_bank_type bank,
                                          input logic [1:0] row,
                                          input logic [1:0] col);
      vp_reg_type word;
      word = bank[{row, col[1]}];
      return col[0] ? sext_coord(word[VP_REG_W-1:FIELD_W])
                    : sext_coord(word[FIELD_W-1:0]);
   endfunction

endpackage

// ===== rtl/core/fpc_coef.sv =====
// Matrix registers and the plane coefficient register for the frustum unit.
// Depends on fpc_pkg.
`timescale 1ns / 1ps

module fpc_coef
   import fpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [VP_REG_W-1:0]    csr_wdata,
   output plane_coef_set_type     coef
);

   vp_bank_type        vp_bank_ff, vp_bank_in;
   plane_coef_set_type coef_ff, coef_in;

   always_comb begin
      vp_bank_in = vp_bank_ff;
      if (csr_write_en && (csr_index < CSR_INDEX_W'(VP_REG_COUNT))) begin
         vp_bank_in[csr_index[VP_SEL_W-1:0]] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_bank_ff <= '0;
      end else begin
         vp_bank_ff <= vp_bank_in;
      end
   end

   // Plane k is column 4 plus (k even) or minus (k odd) column 1 + k/2.
   always_comb begin
      coef_val_type tmp [ROW_COUNT];
      coef_val_type base;
      coef_val_type other;
      for (int k = 0; k < PLANE_COUNT; k++) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            base  = COEF_W'(vp_entry(vp_bank_ff, 2'(r), 2'(ROW_COUNT - 1)));
            other = COEF_W'(vp_entry(vp_bank_ff, 2'(r), 2'(k >> 1)));
            tmp[r] = (k % 2 == 1) ? (base - other) : (base + other);
         end
         coef_in[k].a    = tmp[0];
         coef_in[k].b    = tmp[1];
         coef_in[k].c    = tmp[2];
         coef_in[k].d    = tmp[3];
         coef_in[k].skip = (tmp[0] == '0) && (tmp[1] == '0) && (tmp[2] == '0);
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   assign coef = coef_ff;

endmodule

// ===== rtl/core/fpc_plane.sv =====
// One frustum plane: three products, a two-level adder and the sign test.
// Depends on fpc_pkg.
`timescale 1ns / 1ps

module fpc_plane
   import fpc_pkg::*;
(
   input  logic           clock,
   input  point_type      point,
   input  plane_coef_type coef,
   output logic           reject
);

   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [PROD_W-1:0] prod_in [3];
   logic signed [ACC_W-1:0]  d_ff, d_in;
   logic signed [ACC_W-1:0]  sum_ff [2];
   logic signed [ACC_W-1:0]  sum_in [2];
   logic signed [ACC_W-1:0]  total;
   logic                     reject_ff, reject_in;

   always_comb begin
      prod_in[0] = PROD_W'(coef.a) * PROD_W'(point.x);
      prod_in[1] = PROD_W'(coef.b) * PROD_W'(point.y);
      prod_in[2] = PROD_W'(coef.c) * PROD_W'(point.z);
      d_in       = ACC_W'(coef.d) <<< FRAC_BITS;
   end

   always_comb begin
      sum_in[0] = ACC_W'(prod_ff[0]) + ACC_W'(prod_ff[1]);
      sum_in[1] = ACC_W'(prod_ff[2]) + d_ff;
   end

   // A plane with an all-zero normal never rejects a point.
   always_comb begin
      total     = sum_ff[0] + sum_ff[1];
      reject_in = total[ACC_W-1] && !coef.skip;
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      d_ff      <= d_in;
      sum_ff    <= sum_in;
      reject_ff <= reject_in;
   end

   assign reject = reject_ff;

endmodule

// ===== rtl/core/frustum_point_containment_unit.sv =====
// Top level of the frustum point containment unit.
// Depends on fpc_pkg, fpc_coef, fpc_plane and the assertion macro header.
`timescale 1ns / 1ps
`include "frustum_point_containment_unit_assert.svh"

// Usage:
// A point transaction (req_point_x/y/z, signed Q16.16) is taken at a rising
// edge where start is high and busy is low. busy is high only during reset,
// so the block takes a new point in every cycle.
// The view-projection matrix sits in eight 64-bit registers written through
// csr_write_en, csr_index and csr_wdata; an index of eight or more is ignored.
// Write the matrix only while no point is in flight: the coefficients follow
// the registers in the next cycle.
// Each accepted point gives one result transaction:
// rsp_valid is high for exactly one cycle with rsp_inside_res, which is 1
// when no frustum plane puts the point on its negative side.
// Throughput is one point per cycle. Latency is set by the pipeline: input
// register, 33x32 multipliers, pair adds, final add and sign, result register.
// The receiver cannot stall; results are simply presented for one cycle.
// Synchronous reset clears the matrix to zero and drops any points in flight.

module frustum_point_containment_unit
   import fpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [FIELD_W-1:0]     req_point_x,
   input  logic [FIELD_W-1:0]     req_point_y,
   input  logic [FIELD_W-1:0]     req_point_z,
   output logic                   rsp_valid,
   output logic                   rsp_inside_res,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [VP_REG_W-1:0]    csr_wdata
);

   logic                   accept;
   point_type              point_ff, point_in;
   logic [PIPE_DEPTH-1:0]  valid_ff, valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_inside_ff, rsp_inside_in;
   plane_coef_set_type     coef;
   logic [PLANE_COUNT-1:0] plane_reject;

   // The pipeline never backs up, so the only time a transaction is refused
   // is while reset is held.
   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      point_in.x = sext_coord(req_point_x);
      point_in.y = sext_coord(req_point_y);
      point_in.z = sext_coord(req_point_z);
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
   end

   // Valid bits ride alongside the data, one per register stage.
   always_comb begin
      valid_in = {valid_ff[PIPE_DEPTH-2:0], accept};
      rsp_valid_in  = valid_ff[PIPE_DEPTH-1];
      rsp_inside_in = !(|plane_reject);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_inside_ff <= rsp_inside_in;
   end

   fpc_coef u_coef (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .coef         (coef)
   );

   // Six identical plane lanes work on the same point in parallel.
   for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_plane
      fpc_plane u_plane (
         .clock  (clock),
         .point  (point_ff),
         .coef   (coef[k]),
         .reject (plane_reject[k])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

   `FPC_ASSERT_NEXT(a_accept_enters, clock, reset, accept, valid_ff[0])
   `FPC_ASSERT_NEXT(a_last_stage_out, clock, reset, valid_ff[PIPE_DEPTH-1], rsp_valid)
   `FPC_ASSERT_NEXT(a_no_phantom, clock, reset, !valid_ff[PIPE_DEPTH-1], !rsp_valid)
   `FPC_ASSERT_SAME(a_never_busy, clock, reset, 1'b1, !busy)

endmodule

// ===== tb/frustum_point_containment_unit_test.sv =====
// Self-checking testbench for the frustum point containment unit.
// Depends on fpc_pkg and the frustum_point_containment_unit top level.
`timescale 1ns / 1ps

module frustum_point_containment_unit_test;
   import fpc_pkg::*;

   // The run is stopped by force after this many clock cycles. A correct run
   // ends well before this limit, even with every gap at its longest.
   localparam int CYCLE_LIMIT = 400000;

   // Cycles left to pass before and after a matrix update. This covers the
   // pipeline from the input register to the result strobe, plus the
   // coefficient register that the plane coefficients pass through.
   localparam int SETTLE_CYCLES = PIPE_DEPTH + 4;

   localparam int RANDOM_PHASES    = 10;
   localparam int POINTS_PER_PHASE = 113;

   // Q16.16 values that the directed part leans on.
   localparam coord_type FIX_ONE = 32'sh0001_0000;
   localparam coord_type FIX_MAX = 32'sh7FFF_FFFF;
   localparam coord_type FIX_MIN = 32'sh8000_0000;

   // Register indexes at or above this value address no register at all.
   localparam int FIRST_UNUSED_INDEX = VP_REG_COUNT;

   // Shapes of view-projection matrix that the run goes through.
   typedef enum int {
      MAT_IDENTITY,
      MAT_SATURATED,
      MAT_FLAT_RIGHT,
      MAT_WIDE,
      MAT_NEAR_DIAG,
      MAT_FOLDED,
      MAT_EXTREME
   } matrix_kind_e;

   typedef logic signed [127:0] wide_sum_type;

   // The scoreboard keeps its own copy of the eight matrix registers and
   // predicts the containment verdict of every point transaction the unit
   // accepts. Verdicts come back strictly in order, so a plain queue holds
   // the expected ones.
   class containment_scoreboard;
      vp_reg_type matrix [VP_REG_COUNT] = '{default: '0};
      bit         expected_inside [$];
      int         failures = 0;

      function void write_reg(logic [CSR_INDEX_W-1:0] index, vp_reg_type value);
         if (index < VP_REG_COUNT)
            matrix[index] = value;
      endfunction

      // Entry at a zero-based row and column of the matrix.
      function coord_type entry_at(int row, int col);
         vp_reg_type word;
         word = matrix[row * 2 + col / 2];
         return (col % 2) ? coord_type'(word[VP_REG_W-1:FIELD_W])
                          : coord_type'(word[FIELD_W-1:0]);
      endfunction

      function bit predict_inside(coord_type px, coord_type py, coord_type pz);
         wide_sum_type pt [3];
         wide_sum_type coef [4];
         wide_sum_type base;
         wide_sum_type other;
         wide_sum_type acc;
         int           col;
         pt[0] = px;
         pt[1] = py;
         pt[2] = pz;
         for (int k = 0; k < PLANE_COUNT; k++) begin
            col = k / 2;
            for (int r = 0; r < ROW_COUNT; r++) begin
               base  = entry_at(r, 3);
               other = entry_at(r, col);
               coef[r] = (k % 2) ? base - other : base + other;
            end
            // A plane without a normal never rejects anything.
            if (coef[0] == 0 && coef[1] == 0 && coef[2] == 0)
               continue;
            acc = (coef[3] <<< FRAC_BITS) + coef[0] * pt[0] + coef[1] * pt[1]
                  + coef[2] * pt[2];
            if (acc < 0)
               return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_point(coord_type px, coord_type py, coord_type pz);
         expected_inside.push_back(predict_inside(px, py, pz));
      endfunction

      function void check_result(logic got);
         bit want;
         if (expected_inside.size() == 0) begin
            $error("inside_res: no transaction outstanding, actual %b", got);
            failures++;
            return;
         end
         want = expected_inside.pop_front();
         if (got !== want) begin
            $error("inside_res: expected %0d, actual %b", want, got);
            failures++;
         end
      endfunction

      function int pending();
         return expected_inside.size();
      endfunction
   endclass

   // Every input of the unit starts at a known value, with reset high.
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [FIELD_W-1:0]     req_point_x = '0;
   logic [FIELD_W-1:0]     req_point_y = '0;
   logic [FIELD_W-1:0]     req_point_z = '0;
   logic                   rsp_valid;
   logic                   rsp_inside_res;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [VP_REG_W-1:0]    csr_wdata = '0;

   containment_scoreboard sb;
   int                    cycle_count = 0;

   // Matrix that the stimulus is about to load, indexed by row and column.
   coord_type mat [ROW_COUNT][ROW_COUNT];

   frustum_point_containment_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .rsp_valid      (rsp_valid),
      .rsp_inside_res (rsp_inside_res),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung unit or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Monitor. Everything is sampled at the rising edge, before the stimulus
   // updates its nonblocking assignments, so the values seen here are the ones
   // the unit itself registers at this edge. Register writes go into the
   // scoreboard copy, accepted points become expectations, and every strobed
   // result is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_en)
            sb.write_reg(csr_index, csr_wdata);
         if (start && !busy)
            sb.note_point(req_point_x, req_point_y, req_point_z);
         if (rsp_valid)
            sb.check_result(rsp_inside_res);
      end
   end

   // Gap before the next transaction: mostly none or short, sometimes long.
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 88)
         return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic coord_type small_fixed(int unsigned span);
      return coord_type'(int'($urandom_range(0, 2 * span)) - int'(span));
   endfunction

   function automatic coord_type pick_extreme();
      case ($urandom_range(0, 5))
         0:       return FIX_MAX;
         1:       return FIX_MIN;
         2:       return '0;
         3:       return -1;
         4:       return 1;
         default: return FIX_ONE;
      endcase
   endfunction

   // Half of the coordinates are small enough to land near the frustum, which
   // keeps both verdicts common; the rest are full-range or extreme values.
   function automatic coord_type pick_coord();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return small_fixed(32'h0003_0000);
      if (roll < 80)
         return coord_type'($urandom);
      return pick_extreme();
   endfunction

   task automatic fill_matrix(matrix_kind_e kind);
      for (int r = 0; r < ROW_COUNT; r++)
         for (int c = 0; c < ROW_COUNT; c++)
            mat[r][c] = '0;
      case (kind)
         MAT_IDENTITY: begin
            // Unit cube: each coordinate must stay within plus or minus one.
            for (int r = 0; r < ROW_COUNT; r++)
               mat[r][r] = FIX_ONE;
         end
         MAT_SATURATED: begin
            // Coefficients as large as the entries allow, in both directions.
            for (int r = 0; r < ROW_COUNT; r++)
               for (int c = 0; c < ROW_COUNT; c++)
                  mat[r][c] = (c == 3) ? FIX_MAX : FIX_MIN;
         end
         MAT_FLAT_RIGHT: begin
            // Column 1 equals column 4 in the first three rows, so the right
            // plane has no normal. Its offset alone would be negative, but a
            // plane like that must never reject a point.
            mat[1][1] = FIX_ONE;
            mat[2][2] = FIX_ONE;
            for (int r = 0; r < 3; r++) begin
               mat[r][0] = small_fixed(32'h0002_0000);
               mat[r][3] = mat[r][0];
            end
            mat[3][0] = 2 * FIX_ONE;
            mat[3][3] = FIX_ONE;
         end
         MAT_WIDE: begin
            for (int r = 0; r < ROW_COUNT; r++)
               for (int c = 0; c < ROW_COUNT; c++)
                  mat[r][c] = coord_type'($urandom);
         end
         MAT_NEAR_DIAG, MAT_FOLDED: begin
            for (int r = 0; r < ROW_COUNT; r++)
               for (int c = 0; c < ROW_COUNT; c++)
                  mat[r][c] = (r == c) ? coord_type'($urandom_range(32'h4000, 32'h3_0000))
                                       : small_fixed(32'h4000);
            // Folding copies column 4 into other columns, with a random sign
            // per row; like signs flatten that column's minus or plus plane.
            if (kind == MAT_FOLDED) begin
               for (int c = 0; c < 3; c++) begin
                  if ($urandom_range(0, 1)) begin
                     for (int r = 0; r < 3; r++)
                        mat[r][c] = $urandom_range(0, 1) ? mat[r][3] : -mat[r][3];
                  end
               end
            end
         end
         default: begin
            for (int r = 0; r < ROW_COUNT; r++)
               for (int c = 0; c < ROW_COUNT; c++)
                  mat[r][c] = pick_extreme();
         end
      endcase
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // Loads mat into the unit while no point is in flight. The registers are
   // written in a shuffled order, with writes to unused indexes mixed in;
   // those must leave the matrix alone.
   task automatic program_matrix();
      int order [VP_REG_COUNT];
      int pick;
      int held;
      int row;
      int col;
      start <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int i = 0; i < VP_REG_COUNT; i++)
         order[i] = i;
      for (int i = VP_REG_COUNT - 1; i > 0; i--) begin
         pick        = $urandom_range(0, i);
         held        = order[i];
         order[i]    = order[pick];
         order[pick] = held;
      end
      for (int i = 0; i < VP_REG_COUNT; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            csr_write_en <= 1'b1;
            csr_index    <= CSR_INDEX_W'($urandom_range(FIRST_UNUSED_INDEX,
                                                        2 ** CSR_INDEX_W - 1));
            csr_wdata    <= {$urandom, $urandom};
            @(posedge clock);
         end
         row = order[i] / 2;
         col = 2 * (order[i] % 2);
         csr_write_en <= 1'b1;
         csr_index    <= CSR_INDEX_W'(order[i]);
         csr_wdata    <= {mat[row][col + 1], mat[row][col]};
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Presents one point transaction and returns after the accepting edge.
   // start is left high, so a following transaction can go back to back; the
   // optional gap lowers it and puts noise on the point ports meanwhile.
   task automatic issue_point(coord_type px, coord_type py, coord_type pz, bit gappy);
      int gap;
      start       <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      req_point_z <= pz;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      gap = gappy ? idle_len() : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) begin
            req_point_x <= $urandom;
            req_point_y <= $urandom;
            req_point_z <= $urandom;
            @(posedge clock);
         end
      end
   endtask

   initial begin
      matrix_kind_e kind;
      bit           gappy;
      sb = new;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Matrix still at its reset value: every plane is flat, so even the
      // most extreme points count as inside.
      issue_point('0, '0, '0, 1'b1);
      issue_point(FIX_MAX, FIX_MAX, FIX_MAX, 1'b1);
      issue_point(FIX_MIN, FIX_MIN, FIX_MIN, 1'b1);

      // Unit cube: points on a face are inside, one step past it outside.
      fill_matrix(MAT_IDENTITY);
      program_matrix();
      issue_point('0, '0, '0, 1'b1);
      issue_point(FIX_ONE, '0, '0, 1'b1);
      issue_point(FIX_ONE + 1, '0, '0, 1'b1);
      issue_point(-FIX_ONE, '0, '0, 1'b0);
      issue_point(-FIX_ONE - 1, '0, '0, 1'b0);
      issue_point('0, -FIX_ONE - 1, '0, 1'b1);
      issue_point('0, FIX_ONE, FIX_ONE, 1'b1);
      issue_point('0, '0, FIX_ONE + 1, 1'b1);
      issue_point(FIX_MAX, FIX_MAX, FIX_MAX, 1'b1);
      issue_point(FIX_MIN, FIX_MIN, FIX_MIN, 1'b1);

      // Largest coefficients against the largest coordinates: the sums must
      // come out exact with no wrap in either direction.
      fill_matrix(MAT_SATURATED);
      program_matrix();
      issue_point(FIX_MAX, FIX_MAX, FIX_MAX, 1'b1);
      issue_point(FIX_MIN, FIX_MIN, FIX_MIN, 1'b1);
      issue_point(FIX_MIN, FIX_MAX, -1, 1'b1);
      issue_point('0, '0, '0, 1'b1);

      // A flat plane whose offset alone would reject the point.
      fill_matrix(MAT_FLAT_RIGHT);
      program_matrix();
      issue_point('0, '0, '0, 1'b1);
      issue_point(FIX_ONE, FIX_ONE, -FIX_ONE, 1'b1);
      issue_point(FIX_MAX, '0, FIX_MIN, 1'b1);

      // Random phases: a fresh matrix each time, then a stream of points.
      // About a third of the phases run without any gaps at all.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         kind  = matrix_kind_e'($urandom_range(MAT_IDENTITY, MAT_EXTREME));
         gappy = ($urandom_range(0, 2) != 0);
         fill_matrix(kind);
         program_matrix();
         for (int n = 0; n < POINTS_PER_PHASE; n++)
            issue_point(pick_coord(), pick_coord(), pick_coord(), gappy);
      end

      start <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      // A verdict that never came back leaves an expectation behind.
      if (sb.pending() != 0) begin
         $error("inside_res: %0d transactions without a result", sb.pending());
         sb.failures++;
      end

      if (sb.failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
